>>> rtl/salru_pkg.sv
// ----------------------------------------------------------------------------
// salru_pkg: shared types and constants of the set-associative LRU controller
// Address and stamp widths, register map, configuration reset values and the
// layout of one stored cache line.
// ----------------------------------------------------------------------------
package salru_pkg;

  // Fixed field widths.
  localparam int ADDR_BITS       = 16;
  localparam int STAMP_W         = 32;
  localparam int WAY_OUT_W       = 3;
  localparam int MAX_OFFSET_BITS = 6;

  // Defaults for the geometry parameters of the top level.
  localparam int DEF_MAX_SETS = 256;
  localparam int DEF_MAX_WAYS = 8;

  // Configuration register map, one 32-bit register per word.
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;

  typedef enum logic [1:0] {
    REG_OFFSET_BITS = 2'd0,
    REG_INDEX_BITS  = 2'd1,
    REG_WAYS_IN_USE = 2'd2,
    REG_WRITE_BACK  = 2'd3
  } reg_idx_t;

  // Configuration reset values.
  localparam logic [2:0] RST_OFFSET_BITS = 3'd4;
  localparam logic [3:0] RST_INDEX_BITS  = 4'd4;
  localparam logic [3:0] RST_WAYS_IN_USE = 4'd1;
  localparam logic       RST_WRITE_BACK  = 1'b1;

  // One stored line: state bits, tag and last-use stamp.
  typedef struct packed {
    logic                 valid;
    logic                 dirty;
    logic [ADDR_BITS-1:0] tag;
    logic [STAMP_W-1:0]   stamp;
  } line_t;

endpackage

>>> rtl/set_assoc_lru_cache_controller_top.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_controller_top: tag and replacement control of a cache
// Looks up each load or store in one set of a set-associative tag store and
// reports hit, filled way, write-back victim and write-through traffic.
// ----------------------------------------------------------------------------
// A new item is taken only once the last has committed (in_stall high until
// then). Each item reads the whole set row from the tag memory, compares tags,
// forms ages, reduces the oldest-way tree level by level and writes the row
// back (not on a write-through store miss) as the result enters the output
// register. After reset the block clears the tag memory one set per cycle
// with in_stall high; configuration writes are taken as ever. A finished
// result waits in the output register without blocking the next item's lookup.
// The user writes configuration only while the block is idle; not enforced.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_controller_top #(
  parameter int MAX_SETS = salru_pkg::DEF_MAX_SETS,
  parameter int MAX_WAYS = salru_pkg::DEF_MAX_WAYS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration port.
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [salru_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [salru_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [salru_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                 pready,
  // Request channel.
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 operation,
  input  logic [salru_pkg::ADDR_BITS-1:0]      address,
  // Result channel.
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 hit,
  output logic [salru_pkg::WAY_OUT_W-1:0]      way,
  output logic                                 allocated,
  output logic                                 victim_written_back,
  output logic [salru_pkg::ADDR_BITS-1:0]      writeback_address,
  output logic                                 memory_write
);

  localparam int AW    = salru_pkg::ADDR_BITS;
  localparam int SW    = salru_pkg::STAMP_W;
  localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  // Largest usable index width: floor of log2 of MAX_SETS.
  localparam int MIB   = $clog2(MAX_SETS + 1) - 1;

  typedef salru_pkg::line_t [MAX_WAYS-1:0] row_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_PICK
  } state_t;

  // Configuration registers.
  logic [2:0] offset_bits;
  logic [3:0] index_bits;
  logic [3:0] ways_in_use;
  logic       write_back;

  // Control and request registers.
  state_t           state;
  logic [SET_W-1:0] clr_idx;
  logic [SW-1:0]    access_count;
  logic             req_op;
  logic [AW-1:0]    req_tag;
  logic [SET_W-1:0] req_set;
  logic             hit_q;
  logic [WAY_W-1:0] hit_way_q;
  logic             have_inv_q;
  logic [WAY_W-1:0] inv_way_q;

  // Tag memory.
  row_t             tag_mem [MAX_SETS];
  row_t             rd_row;
  logic             mem_re;
  logic             mem_we;
  logic [SET_W-1:0] mem_waddr;
  row_t             mem_wdata;

  // Address split.
  logic [2:0]    ob_eff;
  logic [3:0]    ib_eff;
  logic [4:0]    nw_eff;
  logic [4:0]    tag_sh;
  logic [AW-1:0] in_set_full;
  logic [AW-1:0] in_tag;
  logic          accept;

  // Lookup results.
  logic [MAX_WAYS-1:0]         in_use;
  logic [MAX_WAYS-1:0]         match;
  logic [MAX_WAYS-1:0]         inval;
  logic [MAX_WAYS-1:0][SW-1:0] ages;
  logic [WAY_W-1:0]            match_way;
  logic [WAY_W-1:0]            inval_way;
  logic                        tree_load;
  logic                        tree_done;
  logic [WAY_W-1:0]            tree_way;

  // Commit results.
  logic             commit;
  logic             no_fill;
  logic [WAY_W-1:0] vict;
  row_t             row_next;
  logic             res_alloc;
  logic             res_wbk;
  logic [AW-1:0]    res_wbaddr;
  logic             res_memw;
  logic [WAY_W-1:0] res_way;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= salru_pkg::RST_OFFSET_BITS;
      index_bits  <= salru_pkg::RST_INDEX_BITS;
      ways_in_use <= salru_pkg::RST_WAYS_IN_USE;
      write_back  <= salru_pkg::RST_WRITE_BACK;
    end else if (psel && penable && pwrite) begin
      case (salru_pkg::reg_idx_t'(paddr[3:2]))
        salru_pkg::REG_OFFSET_BITS: offset_bits <= pwdata[2:0];
        salru_pkg::REG_INDEX_BITS:  index_bits  <= pwdata[3:0];
        salru_pkg::REG_WAYS_IN_USE: ways_in_use <= pwdata[3:0];
        salru_pkg::REG_WRITE_BACK:  write_back  <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (salru_pkg::reg_idx_t'(paddr[3:2]))
      salru_pkg::REG_OFFSET_BITS: prdata = salru_pkg::CFG_DATA_W'(offset_bits);
      salru_pkg::REG_INDEX_BITS:  prdata = salru_pkg::CFG_DATA_W'(index_bits);
      salru_pkg::REG_WAYS_IN_USE: prdata = salru_pkg::CFG_DATA_W'(ways_in_use);
      salru_pkg::REG_WRITE_BACK:  prdata = salru_pkg::CFG_DATA_W'(write_back);
      default:                    prdata = '0;
    endcase
  end

  // ----------------------------------------------------------- address split
  // Field widths saturate to what the geometry supports.
  always_comb begin
    ob_eff = (offset_bits > 3'(salru_pkg::MAX_OFFSET_BITS)) ?
             3'(salru_pkg::MAX_OFFSET_BITS) : offset_bits;
    ib_eff = (index_bits > 4'(MIB)) ? 4'(MIB) : index_bits;
    if (ways_in_use == 4'd0) begin
      nw_eff = 5'd1;
    end else if ({1'b0, ways_in_use} > 5'(MAX_WAYS)) begin
      nw_eff = 5'(MAX_WAYS);
    end else begin
      nw_eff = {1'b0, ways_in_use};
    end
    tag_sh      = {2'b00, ob_eff} + {1'b0, ib_eff};
    in_set_full = (address >> ob_eff) & ((AW'(1) << ib_eff) - AW'(1));
    in_tag      = address >> tag_sh;
  end

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // ------------------------------------------------------------ tag memory
  // The set row is read at the accept edge and written at the commit edge.
  assign mem_re = accept;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tag_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_row <= tag_mem[SET_W'(in_set_full)];
    end
  end

  // ---------------------------------------------------------------- lookup
  // Tag compare over the ways in use and ages of every way; lowest way has priority.
  always_comb begin
    match_way = '0;
    inval_way = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      in_use[w] = (5'(w) < nw_eff);
      match[w]  = in_use[w] && rd_row[w].valid && (rd_row[w].tag == req_tag);
      inval[w]  = in_use[w] && !rd_row[w].valid;
      ages[w]   = access_count - rd_row[w].stamp;
    end
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        match_way = WAY_W'(w);
      end
      if (inval[w]) begin
        inval_way = WAY_W'(w);
      end
    end
  end

  assign tree_load = (state == ST_LOOK);

  salru_victim_sel #(
    .MAX_WAYS (MAX_WAYS)
  ) u_victim (
    .clk    (clk),
    .rst    (rst),
    .load   (tree_load),
    .in_use (in_use),
    .ages   (ages),
    .done   (tree_done),
    .victim (tree_way)
  );

  // ---------------------------------------------------------------- commit
  assign commit = (state == ST_PICK) && tree_done && (!out_valid || !out_stall);

  // Update the set row and form the result.
  always_comb begin
    row_next   = rd_row;
    no_fill    = 1'b0;
    vict       = have_inv_q ? inv_way_q : tree_way;
    res_alloc  = 1'b0;
    res_wbk    = 1'b0;
    res_wbaddr = '0;
    res_memw   = 1'b0;
    res_way    = '0;
    if (hit_q) begin
      res_way                   = hit_way_q;
      row_next[hit_way_q].stamp = access_count;
      if (req_op) begin
        if (write_back) begin
          row_next[hit_way_q].dirty = 1'b1;
        end else begin
          res_memw = 1'b1;
        end
      end
    end else if (req_op && !write_back) begin
      // Write-through store miss goes to memory without a fill.
      res_memw = 1'b1;
      no_fill  = 1'b1;
    end else begin
      if (!have_inv_q && write_back && rd_row[vict].dirty) begin
        res_wbk    = 1'b1;
        res_wbaddr = (rd_row[vict].tag << tag_sh) | (AW'(req_set) << ob_eff);
      end
      row_next[vict].valid = 1'b1;
      row_next[vict].dirty = req_op;
      row_next[vict].tag   = req_tag;
      row_next[vict].stamp = access_count;
      res_way              = vict;
      res_alloc            = 1'b1;
    end
  end

  // Memory write port: clearing pass or commit.
  always_comb begin
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx;
      mem_wdata = '0;
    end else begin
      mem_we    = commit && !no_fill;
      mem_waddr = req_set;
      mem_wdata = row_next;
    end
  end

  // ------------------------------------------------------- sequencer
  // State, request registers and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_idx      <= '0;
      access_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      // The output register refills on commit and empties when taken.
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + SET_W'(1);
          if (clr_idx == SET_W'(MAX_SETS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            req_op  <= operation;
            req_tag <= in_tag;
            req_set <= SET_W'(in_set_full);
            state   <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          hit_q      <= |match;
          hit_way_q  <= match_way;
          have_inv_q <= |inval;
          inv_way_q  <= inval_way;
          state      <= ST_PICK;
        end
        ST_PICK: begin
          if (commit) begin
            hit                 <= hit_q;
            way                 <= salru_pkg::WAY_OUT_W'(res_way);
            allocated           <= res_alloc;
            victim_written_back <= res_wbk;
            writeback_address   <= res_wbaddr;
            memory_write        <= res_memw;
            access_count        <= access_count + SW'(1);
            state               <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/salru_victim_sel.sv
// ----------------------------------------------------------------------------
// salru_victim_sel: oldest-way search over one set
// Reduces the ages of all ways pairwise, one tree level per cycle. Adjacent
// slots are combined so the lower way wins a tie. The result holds until the
// next load.
// ----------------------------------------------------------------------------
module salru_victim_sel #(
  parameter int MAX_WAYS = salru_pkg::DEF_MAX_WAYS
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        load,
  input  logic [MAX_WAYS-1:0]                         in_use,
  input  logic [MAX_WAYS-1:0][salru_pkg::STAMP_W-1:0] ages,
  output logic                                        done,
  output logic [((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1)-1:0] victim
);

  localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int LEVELS = $clog2(MAX_WAYS);
  localparam int SLOTS  = 1 << LEVELS;
  localparam int LVL_W  = (LEVELS > 0) ? $clog2(LEVELS + 1) : 1;

  typedef struct packed {
    logic                          live;
    logic [salru_pkg::STAMP_W-1:0] age;
    logic [WAY_W-1:0]              way;
  } slot_t;

  slot_t            slots      [SLOTS];
  slot_t            slots_next [SLOTS];
  slot_t            load_slots [SLOTS];
  logic             busy;
  logic [LVL_W-1:0] lvl;

  // Initial slot contents: one per way, padding slots never win.
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      load_slots[i] = '0;
    end
    for (int i = 0; i < MAX_WAYS; i++) begin
      load_slots[i].live = in_use[i];
      load_slots[i].age  = ages[i];
      load_slots[i].way  = WAY_W'(i);
    end
  end

  // One tree level: the right slot wins only with a strictly greater age.
  always_comb begin
    for (int i = 0; i < SLOTS / 2; i++) begin
      if (slots[2*i+1].live && (!slots[2*i].live || slots[2*i+1].age > slots[2*i].age)) begin
        slots_next[i] = slots[2*i+1];
      end else begin
        slots_next[i] = slots[2*i];
      end
    end
    for (int i = SLOTS / 2; i < SLOTS; i++) begin
      slots_next[i] = '0;
    end
  end

  assign done   = busy && (lvl == LVL_W'(LEVELS));
  assign victim = slots[0].way;

  // Level counter and slot registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      lvl  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      lvl  <= '0;
    end else if (busy && !done) begin
      lvl <= lvl + LVL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slots <= load_slots;
    end else if (busy && !done) begin
      slots <= slots_next;
    end
  end

endmodule

>>> rtl/salru_checker.sv
// ----------------------------------------------------------------------------
// salru_checker: port-level checks of the cache controller
// Watches the handshakes and the consistency of each result item.
// ----------------------------------------------------------------------------
module salru_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic                            hit,
  input logic                            allocated,
  input logic                            victim_written_back,
  input logic [salru_pkg::ADDR_BITS-1:0] writeback_address,
  input logic                            memory_write
);

  // A pending result is not dropped while the receiver stalls.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result item dropped while stalled");

  // The tag memory is being cleared right after reset.
  a_clear_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> in_stall)
    else $error("item input open during clearing pass");

  // Items are handled one at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second item accepted while one is in progress");

  // A hit never fills, evicts or writes a victim back.
  a_hit_no_fill: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> !allocated && !victim_written_back)
    else $error("hit reported together with a fill");

  // Without a write-back the address is zero and no fill writes to memory.
  a_wb_consistent: assert property (@(posedge clk) disable iff (rst)
    out_valid && !victim_written_back |-> writeback_address == '0 &&
    !(memory_write && allocated))
    else $error("inconsistent write-back or memory write result");

endmodule

bind set_assoc_lru_cache_controller_top salru_checker u_salru_checker (.*);

>>> tb/tag_replacement_check.sv
// ----------------------------------------------------------------------------
// tag_replacement_check: lookup predictor and result comparator
// Follows configuration writes and accepted accesses. It keeps its own copy
// of the tag store and works out hit, fill way, write-back victim and
// write-through traffic for every access. Each accepted result is then
// compared with the oldest outstanding prediction. Register reads are also
// compared against the predicted register values.
// ----------------------------------------------------------------------------
module tag_replacement_check #(
  parameter int MAX_SETS = salru_pkg::DEF_MAX_SETS,
  parameter int MAX_WAYS = salru_pkg::DEF_MAX_WAYS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [salru_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [salru_pkg::CFG_DATA_W-1:0] pwdata,
  input  logic [salru_pkg::CFG_DATA_W-1:0] prdata,
  input  logic                             pready,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic                             operation,
  input  logic [salru_pkg::ADDR_BITS-1:0]  address,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic                             hit,
  input  logic [salru_pkg::WAY_OUT_W-1:0]  way,
  input  logic                             allocated,
  input  logic                             victim_written_back,
  input  logic [salru_pkg::ADDR_BITS-1:0]  writeback_address,
  input  logic                             memory_write,
  output int                               mismatches,
  output int                               pending,
  output int                               lookups_checked
);
  import salru_pkg::*;

  localparam int LINES       = MAX_SETS * MAX_WAYS;
  // Largest usable index width: floor of log2 of MAX_SETS.
  localparam int INDEX_LIMIT = $clog2(MAX_SETS + 1) - 1;

  typedef struct packed {
    logic                 hit;
    logic [WAY_OUT_W-1:0] way;
    logic                 allocated;
    logic                 victim_written_back;
    logic [ADDR_BITS-1:0] writeback_address;
    logic                 memory_write;
  } lookup_result_t;

  // Shadow copy of the configuration registers.
  logic [2:0] offset_reg;
  logic [3:0] index_reg;
  logic [3:0] ways_reg;
  logic       write_back_reg;

  // Shadow copy of the tag store and the access counter.
  bit                 tag_valid [LINES];
  bit                 tag_dirty [LINES];
  bit [ADDR_BITS-1:0] tag_value [LINES];
  bit [STAMP_W-1:0]   last_use  [LINES];
  bit [STAMP_W-1:0]   use_clock;

  lookup_result_t expected_lookups [$];

  // Looks up one access in the shadow store, updates it and returns the
  // result that the block should report for it.
  function automatic lookup_result_t lookup_line(input logic op, input logic [15:0] a);
    lookup_result_t r;
    int unsigned addr_w, ob, ib, nw, set_num, tag, base, victim, w;
    bit [STAMP_W-1:0] age, oldest;
    bit [31:0] wb_full;
    bit found, spare;
    r = '0;
    found = 0;
    spare = 0;
    victim = 0;
    oldest = 0;
    addr_w = 32'(a);
    // Oversized register values saturate.
    ob = (offset_reg > MAX_OFFSET_BITS) ? MAX_OFFSET_BITS : offset_reg;
    ib = (index_reg > INDEX_LIMIT) ? INDEX_LIMIT : index_reg;
    nw = (ways_reg == 0) ? 1 : ((ways_reg > MAX_WAYS) ? MAX_WAYS : ways_reg);
    set_num = (addr_w >> ob) & ((1 << ib) - 1);
    tag = addr_w >> (ob + ib);
    base = set_num * MAX_WAYS;

    // Search the ways in use; the lowest matching way wins.
    for (w = 0; w < nw; w++) begin
      if (!found && tag_valid[base + w] && tag_value[base + w] == tag) begin
        found = 1;
        r.way = WAY_OUT_W'(w);
      end
    end

    if (found) begin
      r.hit = 1;
      last_use[base + r.way] = use_clock;
      if (op == 1'b1) begin
        if (write_back_reg) begin
          tag_dirty[base + r.way] = 1;
        end else begin
          r.memory_write = 1;
        end
      end
    end else if (op == 1'b1 && !write_back_reg) begin
      // Write-through store miss goes to memory without a fill.
      r.memory_write = 1;
    end else begin
      // Fill the lowest invalid way, else the oldest one.
      for (w = 0; w < nw; w++) begin
        if (!spare && !tag_valid[base + w]) begin
          spare = 1;
          victim = w;
        end
      end
      if (!spare) begin
        for (w = 0; w < nw; w++) begin
          age = use_clock - last_use[base + w];
          if (w == 0 || age > oldest) begin
            oldest = age;
            victim = w;
          end
        end
        // A dirty victim is only written back in write-back mode.
        if (write_back_reg && tag_dirty[base + victim]) begin
          wb_full = (32'(tag_value[base + victim]) << (ob + ib)) | (set_num << ob);
          r.victim_written_back = 1;
          r.writeback_address = wb_full[ADDR_BITS-1:0];
        end
      end
      tag_valid[base + victim] = 1;
      tag_dirty[base + victim] = op;
      tag_value[base + victim] = ADDR_BITS'(tag);
      last_use[base + victim] = use_clock;
      r.way = WAY_OUT_W'(victim);
      r.allocated = 1;
    end

    use_clock = use_clock + 1;
    return r;
  endfunction

  function automatic string describe(input lookup_result_t r);
    return $sformatf("hit=%0b way=%0d alloc=%0b wb=%0b wb_addr=%04h mem_wr=%0b",
                     r.hit, r.way, r.allocated, r.victim_written_back,
                     r.writeback_address, r.memory_write);
  endfunction

  // Track configuration, predict accepted accesses and compare results.
  always @(posedge clk) begin
    lookup_result_t got;
    lookup_result_t want;
    logic [CFG_DATA_W-1:0] reg_image;
    if (rst) begin
      offset_reg = RST_OFFSET_BITS;
      index_reg = RST_INDEX_BITS;
      ways_reg = RST_WAYS_IN_USE;
      write_back_reg = RST_WRITE_BACK;
      for (int i = 0; i < LINES; i++) begin
        tag_valid[i] = 0;
        tag_dirty[i] = 0;
      end
      use_clock = 0;
      expected_lookups.delete();
    end else begin
      // Register writes and read-back on the configuration port.
      if (psel && penable && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_OFFSET_BITS: reg_image = CFG_DATA_W'(offset_reg);
          REG_INDEX_BITS:  reg_image = CFG_DATA_W'(index_reg);
          REG_WAYS_IN_USE: reg_image = CFG_DATA_W'(ways_reg);
          default:         reg_image = CFG_DATA_W'(write_back_reg);
        endcase
        if (pwrite) begin
          case (reg_idx_t'(paddr[3:2]))
            REG_OFFSET_BITS: offset_reg = pwdata[2:0];
            REG_INDEX_BITS:  index_reg = pwdata[3:0];
            REG_WAYS_IN_USE: ways_reg = pwdata[3:0];
            default:         write_back_reg = pwdata[0];
          endcase
        end else if (prdata !== reg_image) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("ERROR %0t: register %0d read %08h, expected %08h",
                     $time, paddr[3:2], prdata, reg_image);
          end
        end
      end

      if (in_valid && !in_stall) begin
        expected_lookups.push_back(lookup_line(operation, address));
      end

      if (out_valid && !out_stall) begin
        got = {hit, way, allocated, victim_written_back, writeback_address, memory_write};
        if (expected_lookups.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("ERROR %0t: result with no access outstanding: %s",
                     $time, describe(got));
          end
        end else begin
          want = expected_lookups.pop_front();
          lookups_checked++;
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("ERROR %0t: result %0d mismatch", $time, lookups_checked);
              $display("  expected %s", describe(want));
              $display("  actual   %s", describe(got));
            end
          end
        end
      end
    end
    pending = expected_lookups.size();
  end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the set-associative LRU cache controller
// Runs a short directed sequence of loads and stores, then random accesses
// under several cache geometries and both write policies, with random gaps
// on the request side and random stalls on the result side. The checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
  import salru_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  operation = 1'b0;
  logic [ADDR_BITS-1:0]  address = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  hit;
  logic [WAY_OUT_W-1:0]  way;
  logic                  allocated;
  logic                  victim_written_back;
  logic [ADDR_BITS-1:0]  writeback_address;
  logic                  memory_write;

  int mismatches;
  int pending;
  int lookups_checked;

  int          send_gap_pct = 0;
  int          result_stall_pct = 0;
  int unsigned eff_ob = 4;
  int unsigned eff_ib = 4;
  int unsigned eff_nw = 1;
  int          items_sent = 0;
  int          settings_run = 1;

  always #5 clk = ~clk;

  // Random stalls on the result side.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < result_stall_pct);
  end

  set_assoc_lru_cache_controller_top dut (
    .clk                 (clk),
    .rst                 (rst),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .operation           (operation),
    .address             (address),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .hit                 (hit),
    .way                 (way),
    .allocated           (allocated),
    .victim_written_back (victim_written_back),
    .writeback_address   (writeback_address),
    .memory_write        (memory_write)
  );

  tag_replacement_check chk (
    .clk                 (clk),
    .rst                 (rst),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .operation           (operation),
    .address             (address),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .hit                 (hit),
    .way                 (way),
    .allocated           (allocated),
    .victim_written_back (victim_written_back),
    .writeback_address   (writeback_address),
    .memory_write        (memory_write),
    .mismatches          (mismatches),
    .pending             (pending),
    .lookups_checked     (lookups_checked)
  );

  // Hands one access to the block, with a random gap before it. Valid stays
  // high after acceptance so that back-to-back items need no extra edge.
  task automatic send_access(input logic op, input logic [ADDR_BITS-1:0] a);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    address <= a;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // One register transfer: setup cycle, then access cycle until pready.
  task automatic cfg_access(input reg_idx_t r, input logic wr, input logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Waits until every access has its result back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // Writes all four registers, reads them back and notes the geometry that
  // the block will actually use.
  task automatic configure(input int unsigned ob, input int unsigned ib,
                           input int unsigned nw, input int unsigned wb);
    cfg_access(REG_OFFSET_BITS, 1'b1, ob);
    cfg_access(REG_INDEX_BITS, 1'b1, ib);
    cfg_access(REG_WAYS_IN_USE, 1'b1, nw);
    cfg_access(REG_WRITE_BACK, 1'b1, wb);
    cfg_access(REG_OFFSET_BITS, 1'b0, 0);
    cfg_access(REG_INDEX_BITS, 1'b0, 0);
    cfg_access(REG_WAYS_IN_USE, 1'b0, 0);
    cfg_access(REG_WRITE_BACK, 1'b0, 0);
    eff_ob = (ob > MAX_OFFSET_BITS) ? MAX_OFFSET_BITS : ob;
    eff_ib = (ib > $clog2(DEF_MAX_SETS)) ? $clog2(DEF_MAX_SETS) : ib;
    eff_nw = (nw == 0) ? 1 : ((nw > DEF_MAX_WAYS) ? DEF_MAX_WAYS : nw);
    settings_run++;
  endtask

  // One cache setting: configure, then random accesses that mostly reuse a
  // few sets and a small pool of tags so that hits and evictions are common.
  task automatic run_setting(input int unsigned ob, input int unsigned ib,
                             input int unsigned nw, input int unsigned wb,
                             input int count);
    int unsigned tag_top, set_top, pool, tag_base, tag, set_num, off, a;
    int mode;
    logic op;
    configure(ob, ib, nw, wb);
    tag_top = (1 << (ADDR_BITS - eff_ob - eff_ib)) - 1;
    set_top = (1 << eff_ib) - 1;
    pool = (eff_nw + 2 > tag_top) ? tag_top : eff_nw + 2;
    tag_base = $urandom & tag_top;
    for (int k = 0; k < count; k++) begin
      // Rotate through the idle patterns every few dozen items.
      mode = (k / 40 + settings_run) % 4;
      send_gap_pct = (mode == 1) ? 49 : ((mode == 3) ? 20 : 0);
      result_stall_pct = (mode == 2) ? 49 : ((mode == 3) ? 20 : 0);
      op = ($urandom_range(99) < 45);
      if ($urandom_range(99) < 15) begin
        a = $urandom;
      end else begin
        tag = (tag_base + $urandom_range(pool)) & tag_top;
        if ($urandom_range(3) == 0) begin
          set_num = $urandom_range(set_top);
        end else begin
          set_num = $urandom_range(set_top < 3 ? set_top : 3);
        end
        off = $urandom_range((1 << eff_ob) - 1);
        a = (tag << (eff_ob + eff_ib)) | (set_num << eff_ob) | off;
      end
      send_access(op, a[ADDR_BITS-1:0]);
    end
    wait_drained();
  endtask

  // Run limit.
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset geometry: 16-byte blocks, 16 sets, direct mapped, write-back.
    send_access(1'b0, 16'h0000);
    send_access(1'b0, 16'h000F);
    send_access(1'b1, 16'h0004);
    send_access(1'b0, 16'h0100);
    send_access(1'b1, 16'hFFFF);
    send_access(1'b1, 16'h0F0F);
    send_access(1'b0, 16'hFFF0);
    send_access(1'b0, 16'h00F0);
    wait_drained();

    // Two ways, write-through: store hit and miss go to memory, and the
    // dirty line left in set zero is evicted without a write-back.
    configure(4, 4, 2, 0);
    send_access(1'b1, 16'h0F00);
    send_access(1'b1, 16'h0200);
    send_access(1'b0, 16'h0200);
    send_access(1'b0, 16'h0300);
    send_access(1'b0, 16'h0200);
    send_access(1'b1, 16'h0300);
    wait_drained();

    // Random accesses across geometries, including saturated registers.
    run_setting(4, 4, 4, 1, 200);
    run_setting(0, 0, 8, 1, 200);
    run_setting(6, 8, 2, 0, 150);
    run_setting(7, 15, 15, 1, 200);
    run_setting(2, 3, 0, 0, 150);
    run_setting(5, 2, 3, 1, 200);
    run_setting(3, 1, 8, 0, 120);
    run_setting(1, 6, 5, 1, 120);

    repeat (20) @(posedge clk);
    $display("Summary: %0d accesses over %0d cache settings, %0d results checked.",
             items_sent, settings_run, lookups_checked);
    $display("Summary: %0d mismatches, %0d results still outstanding.",
             mismatches, pending);
    if (mismatches == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/salru_pkg.sv
rtl/salru_victim_sel.sv
rtl/set_assoc_lru_cache_controller_top.sv
rtl/salru_checker.sv
tb/tag_replacement_check.sv
tb/tb_top.sv
